FILE: rtl/fpq_pkg.sv
// fpq_pkg: shared types and codes for the four-level priority queue
// holds opcodes, status codes, the controller state type and the interface structs
// no dependencies

package fpq_pkg;

    // opcodes of an input beat
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BADPRIO = 3'd3;
    localparam logic [2:0] ST_NOPOS   = 3'd4;

    // highest legal priority
    localparam logic [2:0] TOP_PRIORITY = 3'd3;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    // memory strobes
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // result of one operation, apart from the descriptor word
    typedef struct packed {
        logic [2:0] status;
        logic       has_data;
        logic [1:0] prio;
        logic [4:0] occ;
    } t_resp;

endpackage

FILE: rtl/fpq_store.sv
// fpq_store: descriptor memory, one bank region per priority level
// single port, registered read data, valid in the cycle after the read strobe
// depends on fpq_pkg (t_mem_ctl)

module fpq_store #(
    parameter int ADDR_W  = 6,
    parameter int DATA_W  = 32
) (
    input  logic                   i_clk,
    input  fpq_pkg::t_mem_ctl      i_ctl,
    input  logic [ADDR_W-1:0]      i_addr,
    input  logic [DATA_W-1:0]      i_wdata,
    output logic [DATA_W-1:0]      o_rdata
);

    localparam int WORDS = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fpq_ctrl.sv
// fpq_ctrl: queue bookkeeping and memory sequencing
// keeps a circular buffer per priority (head and count) and decodes push, pop and peek
// depends on fpq_pkg (codes, t_state, t_mem_ctl, t_resp)

module fpq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_op,
    input  logic [2:0]                            i_priority_req,
    input  logic [31:0]                           i_entry_value,
    input  logic [3:0]                            i_peek_index,
    output logic                                  o_resp_valid,
    input  logic                                  i_resp_take,
    output fpq_pkg::t_resp                        o_resp,
    output fpq_pkg::t_mem_ctl                     o_mem_ctl,
    output logic [$clog2(QUEUE_DEPTH)+1:0]        o_mem_addr,
    output logic [ENTRY_WIDTH-1:0]                o_mem_wdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int KW = (CW > 4) ? CW : 4;
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    fpq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt  [4];
    logic [CW-1:0]   n_cnt  [4];
    logic [AW-1:0]   r_head [4];
    logic [AW-1:0]   n_head [4];
    logic [CW-1:0]   r_total, n_total;
    fpq_pkg::t_resp  r_resp, n_resp;

    logic            in_fire;
    logic [1:0]      push_p;
    logic [1:0]      pop_b;
    logic [1:0]      pk_b;
    logic [KW-1:0]   pk_off;
    logic [KW-1:0]   idx_k;
    logic [KW-1:0]   c3_k, s32_k, s321_k;

    // circular slot arithmetic, operands below the depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign in_fire      = i_in_valid && (r_state == fpq_pkg::S_IDLE);
    assign o_in_ready   = (r_state == fpq_pkg::S_IDLE);
    assign o_resp_valid = (r_state == fpq_pkg::S_RESP);
    assign o_resp       = r_resp;
    assign push_p       = i_priority_req[1:0];
    assign o_mem_wdata  = ENTRY_WIDTH'(i_entry_value);

    // highest non-empty level for a pop
    always_comb begin
        if (r_cnt[3] != '0) begin
            pop_b = 2'd3;
        end else if (r_cnt[2] != '0) begin
            pop_b = 2'd2;
        end else if (r_cnt[1] != '0) begin
            pop_b = 2'd1;
        end else begin
            pop_b = 2'd0;
        end
    end

    // peek position to level and offset within that level
    always_comb begin
        idx_k  = KW'(i_peek_index);
        c3_k   = KW'(r_cnt[3]);
        s32_k  = c3_k + KW'(r_cnt[2]);
        s321_k = s32_k + KW'(r_cnt[1]);
        if (idx_k < c3_k) begin
            pk_b   = 2'd3;
            pk_off = idx_k;
        end else if (idx_k < s32_k) begin
            pk_b   = 2'd2;
            pk_off = idx_k - c3_k;
        end else if (idx_k < s321_k) begin
            pk_b   = 2'd1;
            pk_off = idx_k - s32_k;
        end else begin
            pk_b   = 2'd0;
            pk_off = idx_k - s321_k;
        end
    end

    // operation decode and bookkeeping update
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_head     = r_head;
        n_total    = r_total;
        n_resp     = r_resp;
        o_mem_ctl  = '0;
        o_mem_addr = '0;
        if (in_fire) begin
            n_state         = fpq_pkg::S_RESP;
            n_resp.status   = fpq_pkg::ST_OK;
            n_resp.has_data = 1'b0;
            n_resp.prio     = 2'd0;
            case (i_op)
                fpq_pkg::OP_PUSH: begin
                    if (i_priority_req > fpq_pkg::TOP_PRIORITY) begin
                        n_resp.status = fpq_pkg::ST_BADPRIO;
                    end else if (r_total == DEPTH_C) begin
                        n_resp.status = fpq_pkg::ST_FULL;
                    end else begin
                        o_mem_ctl.we   = 1'b1;
                        o_mem_addr     = {push_p,
                                          wrap_add(r_head[push_p], r_cnt[push_p][AW-1:0])};
                        n_cnt[push_p]  = r_cnt[push_p] + 1'b1;
                        n_total        = r_total + 1'b1;
                    end
                end
                fpq_pkg::OP_POP: begin
                    if (r_total == '0) begin
                        n_resp.status = fpq_pkg::ST_EMPTY;
                    end else begin
                        o_mem_ctl.re    = 1'b1;
                        o_mem_addr      = {pop_b, r_head[pop_b]};
                        n_head[pop_b]   = wrap_add(r_head[pop_b], AW'(1));
                        n_cnt[pop_b]    = r_cnt[pop_b] - 1'b1;
                        n_total         = r_total - 1'b1;
                        n_resp.has_data = 1'b1;
                        n_resp.prio     = pop_b;
                    end
                end
                fpq_pkg::OP_PEEK: begin
                    if (r_total == '0) begin
                        n_resp.status = fpq_pkg::ST_EMPTY;
                    end else if (idx_k >= KW'(r_total)) begin
                        n_resp.status = fpq_pkg::ST_NOPOS;
                    end else begin
                        o_mem_ctl.re    = 1'b1;
                        o_mem_addr      = {pk_b, wrap_add(r_head[pk_b], pk_off[AW-1:0])};
                        n_resp.has_data = 1'b1;
                        n_resp.prio     = pk_b;
                    end
                end
                default: begin
                    n_resp.status = fpq_pkg::ST_OK;
                end
            endcase
            n_resp.occ = 5'(n_total);
        end else if ((r_state == fpq_pkg::S_RESP) && i_resp_take) begin
            n_state = fpq_pkg::S_IDLE;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpq_pkg::S_IDLE;
            r_total <= '0;
            for (int i = 0; i < 4; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        r_resp <= n_resp;
    end

    // running total matches the per-level counts
    a_total_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (KW + 2)'(r_total) == (KW + 2)'(r_cnt[0]) + (KW + 2)'(r_cnt[1])
                             + (KW + 2)'(r_cnt[2]) + (KW + 2)'(r_cnt[3]))
        else $error("total does not match level counts");

    // occupancy never passes the depth
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= DEPTH_C)
        else $error("queue overfilled");

    // a memory read is always followed by the result cycle that uses it
    a_read_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.re |=> (r_state == fpq_pkg::S_RESP) && r_resp.has_data)
        else $error("read data not consumed");

    // memory stays quiet while a result is pending
    a_quiet_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpq_pkg::S_RESP) |-> !o_mem_ctl.we && !o_mem_ctl.re)
        else $error("memory access during result cycle");

endmodule

FILE: rtl/four_level_priority_queue_unit.sv
// four_level_priority_queue_unit: top level of the four-level priority queue
// instantiates fpq_ctrl and fpq_store and holds the result output register
// depends on fpq_pkg, fpq_ctrl and fpq_store
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_op, i_priority_req, i_entry_value,
//                                                   i_peek_index
//   output    out        o_out_valid / i_out_ready  o_status, o_out_value, o_out_priority,
//                                                   o_occupancy
//
// each operation passes through S_IDLE, for the memory access of the level it touches,
// and S_RESP, for the registered read data to reach the output register
// a further beat is taken only once the previous result has moved into the output register
// the output register holds a finished result while the next beat is already accepted
// reset clears the state, total, level counts and heads and the output valid; the memory is never cleared

module four_level_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_priority_req,
    input  logic [31:0] i_entry_value,
    input  logic [3:0]  i_peek_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_value,
    output logic [1:0]  o_out_priority,
    output logic [4:0]  o_occupancy
);

    localparam int MAW = $clog2(QUEUE_DEPTH) + 2;

    fpq_pkg::t_resp     resp;
    fpq_pkg::t_mem_ctl  mem_ctl;
    logic [MAW-1:0]     mem_addr;
    logic [ENTRY_WIDTH-1:0] mem_wdata;
    logic [ENTRY_WIDTH-1:0] mem_rdata;
    logic               resp_valid;
    logic               resp_take;

    logic               r_out_valid;
    logic [2:0]         r_status;
    logic [31:0]        r_value;
    logic [1:0]         r_prio;
    logic [4:0]         r_occ;

    fpq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_priority_req (i_priority_req),
        .i_entry_value  (i_entry_value),
        .i_peek_index   (i_peek_index),
        .o_resp_valid   (resp_valid),
        .i_resp_take    (resp_take),
        .o_resp         (resp),
        .o_mem_ctl      (mem_ctl),
        .o_mem_addr     (mem_addr),
        .o_mem_wdata    (mem_wdata)
    );

    fpq_store #(
        .ADDR_W (MAW),
        .DATA_W (ENTRY_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // result moves in when the output register is empty or draining
    assign resp_take = resp_valid && (!r_out_valid || i_out_ready);

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resp_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (resp_take) begin
            r_status <= resp.status;
            r_value  <= resp.has_data ? 32'(mem_rdata) : 32'd0;
            r_prio   <= resp.prio;
            r_occ    <= resp.occ;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_prio;
    assign o_occupancy    = r_occ;

endmodule

FILE: test/four_level_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// four_level_priority_queue_unit_tb: self-checking testbench for the four-level priority queue
// drives random and directed beats, predicts each result with a local queue model
// depends on fpq_pkg and four_level_priority_queue_unit

module four_level_priority_queue_unit_tb;

    localparam int          QDEPTH     = 16;
    localparam int          RUN_LIMIT  = 1000000;
    localparam logic [1:0]  OP_NONE    = 2'd3;

    // one result as the block should report it
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [1:0]  prio;
        logic [4:0]  occ;
    } t_queue_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [2:0]  i_priority_req;
    logic [31:0] i_entry_value;
    logic [3:0]  i_peek_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [31:0] o_out_value;
    logic [1:0]  o_out_priority;
    logic [4:0]  o_occupancy;

    // local copy of the queue contents, head at index 0
    logic [31:0]   model_value [QDEPTH];
    logic [1:0]    model_prio  [QDEPTH];
    int            model_count;
    t_queue_result pending_results [$];

    int  error_count;
    int  beats_sent;
    int  results_checked;
    int  status_seen [5];
    int  cycle_count;
    bit  idle_off;
    int  out_stall_left;

    four_level_priority_queue_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_priority_req (i_priority_req),
        .i_entry_value  (i_entry_value),
        .i_peek_index   (i_peek_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

    // clock, 4 ns period
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // apply one operation to the local queue and return the result it gives
    function automatic t_queue_result apply_operation(logic [1:0] op, logic [2:0] prio,
                                                      logic [31:0] value, logic [3:0] idx);
        t_queue_result res;
        int            pos;
        res = '0;
        res.status = fpq_pkg::ST_OK;
        case (op)
            fpq_pkg::OP_PUSH: begin
                // priority check comes before the full check
                if (prio > fpq_pkg::TOP_PRIORITY) begin
                    res.status = fpq_pkg::ST_BADPRIO;
                end else if (model_count == QDEPTH) begin
                    res.status = fpq_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < model_count && model_prio[pos] >= prio[1:0])
                        pos++;
                    for (int i = model_count; i > pos; i--) begin
                        model_value[i] = model_value[i-1];
                        model_prio[i]  = model_prio[i-1];
                    end
                    model_value[pos] = value;
                    model_prio[pos]  = prio[1:0];
                    model_count++;
                end
            end
            fpq_pkg::OP_POP: begin
                if (model_count == 0) begin
                    res.status = fpq_pkg::ST_EMPTY;
                end else begin
                    res.value = model_value[0];
                    res.prio  = model_prio[0];
                    for (int i = 1; i < model_count; i++) begin
                        model_value[i-1] = model_value[i];
                        model_prio[i-1]  = model_prio[i];
                    end
                    model_count--;
                end
            end
            fpq_pkg::OP_PEEK: begin
                if (model_count == 0) begin
                    res.status = fpq_pkg::ST_EMPTY;
                end else if (int'(idx) >= model_count) begin
                    res.status = fpq_pkg::ST_NOPOS;
                end else begin
                    res.value = model_value[idx];
                    res.prio  = model_prio[idx];
                end
            end
            default: begin
                // unused opcode leaves the queue alone
            end
        endcase
        res.occ = model_count[4:0];
        return res;
    endfunction

    // send one beat; called and returns at a falling edge
    task automatic send_beat(logic [1:0] op, logic [2:0] prio, logic [31:0] value,
                             logic [3:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_op           = op;
        i_priority_req = prio;
        i_entry_value  = value;
        i_peek_index   = idx;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_results.push_back(apply_operation(op, prio, value, idx));
        beats_sent++;
        @(negedge i_clk);
    endtask

    // result side back-pressure
    always @(negedge i_clk) begin
        if (out_stall_left > 0) begin
            i_out_ready = 1'b0;
            out_stall_left--;
        end else if (idle_off || $urandom_range(0, 99) < 65) begin
            i_out_ready = 1'b1;
        end else begin
            i_out_ready = 1'b0;
            out_stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                         : $urandom_range(10, 40);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction waiting");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.status < 5)
                    status_seen[want.status]++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_out_value !== want.value) begin
                    $error("out_value: expected %08h, got %08h", want.value, o_out_value);
                    error_count++;
                end
                if (o_out_priority !== want.prio) begin
                    $error("out_priority: expected %0d, got %0d", want.prio, o_out_priority);
                    error_count++;
                end
                if (o_occupancy !== want.occ) begin
                    $error("occupancy: expected %0d, got %0d", want.occ, o_occupancy);
                    error_count++;
                end
            end
        end
    end

    // empty queue, unused opcode and out-of-range priorities
    task automatic test_empty_and_illegal();
        send_beat(fpq_pkg::OP_POP,  3'd0, 32'h0, 4'd0);
        send_beat(fpq_pkg::OP_PEEK, 3'd0, 32'h0, 4'd0);
        send_beat(fpq_pkg::OP_PEEK, 3'd3, 32'h0, 4'd15);
        send_beat(OP_NONE, 3'd7, 32'hFFFF_FFFF, 4'd15);
        send_beat(fpq_pkg::OP_PUSH, 3'd4, 32'h1234_5678, 4'd0);
        send_beat(fpq_pkg::OP_PUSH, 3'd7, 32'hFFFF_FFFF, 4'd0);
    endtask

    // service order across levels and within a level, peeks at the edges
    task automatic test_ordering();
        send_beat(fpq_pkg::OP_PUSH, 3'd1, 32'hA5A5_0001, 4'd0);
        send_beat(fpq_pkg::OP_PUSH, 3'd3, 32'hFFFF_FFFF, 4'd0);
        send_beat(fpq_pkg::OP_PUSH, 3'd1, 32'hA5A5_0002, 4'd0);
        send_beat(fpq_pkg::OP_PUSH, 3'd0, 32'h0000_0000, 4'd0);
        send_beat(fpq_pkg::OP_PUSH, 3'd3, 32'h5A5A_0003, 4'd0);
        send_beat(fpq_pkg::OP_PUSH, 3'd2, 32'h8000_0000, 4'd0);
        send_beat(fpq_pkg::OP_PEEK, 3'd0, 32'h0, 4'd0);
        send_beat(fpq_pkg::OP_PEEK, 3'd0, 32'h0, 4'd5);
        send_beat(fpq_pkg::OP_PEEK, 3'd0, 32'h0, 4'd6);
        send_beat(fpq_pkg::OP_PEEK, 3'd0, 32'h0, 4'd15);
        send_beat(OP_NONE, 3'd0, 32'h0, 4'd0);
        repeat (7)
            send_beat(fpq_pkg::OP_POP, 3'd0, 32'h0, 4'd0);
    endtask

    // fill to capacity, overflow, bad priority on a full queue, then drain
    task automatic test_full_queue();
        while (model_count < QDEPTH)
            send_beat(fpq_pkg::OP_PUSH, 3'($urandom_range(0, 3)), $urandom, 4'($urandom));
        send_beat(fpq_pkg::OP_PUSH, 3'd2, 32'hDEAD_BEEF, 4'd0);
        send_beat(fpq_pkg::OP_PUSH, 3'd5, 32'hDEAD_BEEF, 4'd0);
        send_beat(fpq_pkg::OP_PEEK, 3'd0, 32'h0, 4'd15);
        while (model_count > 0)
            send_beat(fpq_pkg::OP_POP, 3'd0, 32'h0, 4'($urandom));
        send_beat(fpq_pkg::OP_POP, 3'd0, 32'h0, 4'd0);
    endtask

    // random traffic in phases that lean towards filling, draining or neither
    task automatic run_traffic(int n_beats);
        int          push_pct;
        int          pop_pct;
        int          r;
        logic [1:0]  op;
        logic [2:0]  prio;
        logic [31:0] value;
        logic [3:0]  idx;
        push_pct = 45;
        pop_pct  = 30;
        for (int n = 0; n < n_beats; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin push_pct = 70; pop_pct = 15; end
                    1: begin push_pct = 20; pop_pct = 60; end
                    default: begin push_pct = 40; pop_pct = 35; end
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_NONE;
            else if (r < 3 + push_pct)
                op = fpq_pkg::OP_PUSH;
            else if (r < 3 + push_pct + pop_pct)
                op = fpq_pkg::OP_POP;
            else
                op = fpq_pkg::OP_PEEK;
            prio = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                               : 3'($urandom_range(0, 3));
            case ($urandom_range(0, 19))
                0:       value = 32'h0;
                1:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            if (model_count > 0 && $urandom_range(0, 9) < 8)
                idx = 4'($urandom_range(0, model_count - 1));
            else
                idx = 4'($urandom);
            send_beat(op, prio, value, idx);
        end
    endtask

    task automatic test_random_traffic();
        idle_off = 1'b0;
        run_traffic(1300);
    endtask

    // both sides at full rate
    task automatic test_back_to_back();
        idle_off = 1'b1;
        run_traffic(250);
        idle_off = 1'b0;
    endtask

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = fpq_pkg::OP_PUSH;
        i_priority_req = 3'd0;
        i_entry_value  = 32'h0;
        i_peek_index   = 4'd0;
        i_out_ready    = 1'b0;
        out_stall_left = 0;
        idle_off       = 1'b0;
        model_count    = 0;
        error_count    = 0;
        beats_sent     = 0;
        results_checked = 0;
        cycle_count    = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_illegal();
        test_ordering();
        test_full_queue();
        test_random_traffic();
        test_back_to_back();
        i_in_valid = 1'b0;

        // let the last results drain, then watch for strays
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d beats sent, %0d results checked in %0d cycles",
                 beats_sent, results_checked, cycle_count);
        $display("results by status: ok %0d, empty %0d, full %0d, bad priority %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("results with no such position: %0d", status_seen[4]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/fpq_pkg.sv
rtl/fpq_store.sv
rtl/fpq_ctrl.sv
rtl/four_level_priority_queue_unit.sv
test/four_level_priority_queue_unit_tb.sv
